/* sv/pst_pkg.sv */
// Package for the pose static transform block: register indexes, widths and
// the shared request struct. Depends on nothing.
package pst_pkg;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd6;

  localparam int STAGES = 4;

  typedef struct packed {
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [31:0] off_x, off_y, off_z;
    logic signed [15:0] sc_x, sc_y, sc_z;
    logic [15:0] gain;
    logic pos_en;
    logic ori_en;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] ex, ey, ez, ew;
    logic [15:0] conf;
    logic [15:0] buttons;
  } req_t;

  // Round half up by 2^n and return the floor.
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] a,
                                               input int n);
    logic signed [63:0] b;
    b = a + (64'sd1 <<< (n - 1));
    return b >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) return 32'sh7fffffff;
    else if (a < -64'sd2147483648) return 32'sh80000000;
    else return a[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] a);
    if (a > 64'sd32767) return 16'sh7fff;
    else if (a < -64'sd32768) return 16'sh8000;
    else return a[15:0];
  endfunction

endpackage

/* sv/pst_cfg_regs.sv */
// Configuration register file for the pose static transform block.
// Depends on pst_pkg.
module pst_cfg_regs import pst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.qx <= '0; cfg.qy <= '0; cfg.qz <= '0; cfg.qw <= 16'sd16384;
      cfg.off_x <= '0; cfg.off_y <= '0; cfg.off_z <= '0;
      cfg.sc_x <= 16'sd4096; cfg.sc_y <= 16'sd4096; cfg.sc_z <= 16'sd4096;
      cfg.gain <= 16'd32768;
      cfg.pos_en <= 1'b0;
      cfg.ori_en <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROT: begin
          cfg.qx <= cfg_data[15:0];  cfg.qy <= cfg_data[31:16];
          cfg.qz <= cfg_data[47:32]; cfg.qw <= cfg_data[63:48];
        end
        REG_OFF_X: cfg.off_x <= cfg_data[31:0];
        REG_OFF_Y: cfg.off_y <= cfg_data[31:0];
        REG_OFF_Z: cfg.off_z <= cfg_data[31:0];
        REG_SCALE: begin
          cfg.sc_x <= cfg_data[15:0]; cfg.sc_y <= cfg_data[31:16];
          cfg.sc_z <= cfg_data[47:32];
        end
        REG_GAIN: cfg.gain <= cfg_data[15:0];
        REG_MODE: begin
          cfg.pos_en <= cfg_data[0];
          cfg.ori_en <= cfg_data[1];
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/pst_datapath.sv */
// Four-stage arithmetic pipeline of the pose static transform block.
// Depends on pst_pkg. Stage enables come from the pipeline control.
module pst_datapath import pst_pkg::*; (
  input  logic              clk,
  input  logic [STAGES-1:0] en,
  input  cfg_t              cfg,
  input  req_t              din,
  output req_t              dout
);

  // Stage 1: first Hamilton product q (x) (v,0), the orientation product
  // and the confidence product.
  // The first product needs 35 bits after rounding; the second one 38.
  logic signed [34:0] s1_tw, s1_tx, s1_ty, s1_tz;
  logic signed [15:0] s1_ox, s1_oy, s1_oz, s1_ow;
  logic [15:0] s1_conf, s1_btn;
  logic signed [31:0] s1_px, s1_py, s1_pz;

  always_ff @(posedge clk) begin
    logic signed [63:0] w, x, y, z;
    logic [32:0] c;
    if (en[0]) begin
      w = -(cfg.qx * din.px + cfg.qy * din.py + cfg.qz * din.pz);
      x = cfg.qw * din.px + cfg.qy * din.pz - cfg.qz * din.py;
      y = cfg.qw * din.py + cfg.qz * din.px - cfg.qx * din.pz;
      z = cfg.qw * din.pz + cfg.qx * din.py - cfg.qy * din.px;
      s1_tw <= 35'(rnd64(w, 14));
      s1_tx <= 35'(rnd64(x, 14));
      s1_ty <= 35'(rnd64(y, 14));
      s1_tz <= 35'(rnd64(z, 14));
      if (cfg.ori_en) begin
        s1_ow <= sat16(rnd64(64'(cfg.qw) * din.ew - cfg.qx * din.ex
                             - cfg.qy * din.ey - cfg.qz * din.ez, 14));
        s1_ox <= sat16(rnd64(64'(cfg.qw) * din.ex + cfg.qx * din.ew
                             + cfg.qy * din.ez - cfg.qz * din.ey, 14));
        s1_oy <= sat16(rnd64(64'(cfg.qw) * din.ey - cfg.qx * din.ez
                             + cfg.qy * din.ew + cfg.qz * din.ex, 14));
        s1_oz <= sat16(rnd64(64'(cfg.qw) * din.ez + cfg.qx * din.ey
                             - cfg.qy * din.ex + cfg.qz * din.ew, 14));
      end else begin
        s1_ox <= din.ex; s1_oy <= din.ey; s1_oz <= din.ez; s1_ow <= din.ew;
      end
      c = (33'(din.conf) * 33'(cfg.gain) + 33'd16384) >> 15;
      s1_conf <= (c > 33'd32768) ? 16'd32768 : c[15:0];
      s1_btn <= din.buttons;
      s1_px <= din.px; s1_py <= din.py; s1_pz <= din.pz;
    end
  end

  // Stage 2: second product t (x) q*, vector part only.
  logic signed [37:0] s2_rx, s2_ry, s2_rz;
  req_t s2;

  always_ff @(posedge clk) begin
    logic signed [63:0] x, y, z;
    if (en[1]) begin
      x = -s1_tw * cfg.qx + s1_tx * cfg.qw - s1_ty * cfg.qz + s1_tz * cfg.qy;
      y = -s1_tw * cfg.qy + s1_tx * cfg.qz + s1_ty * cfg.qw - s1_tz * cfg.qx;
      z = -s1_tw * cfg.qz - s1_tx * cfg.qy + s1_ty * cfg.qx + s1_tz * cfg.qw;
      s2_rx <= 38'(rnd64(x, 14));
      s2_ry <= 38'(rnd64(y, 14));
      s2_rz <= 38'(rnd64(z, 14));
      s2 <= '{px: s1_px, py: s1_py, pz: s1_pz, ex: s1_ox, ey: s1_oy,
              ez: s1_oz, ew: s1_ow, conf: s1_conf, buttons: s1_btn};
    end
  end

  // Stage 3: per-axis scale.
  logic signed [63:0] s3_sx, s3_sy, s3_sz;
  req_t s3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_sx <= rnd64(64'(s2_rx) * cfg.sc_x, 12);
      s3_sy <= rnd64(64'(s2_ry) * cfg.sc_y, 12);
      s3_sz <= rnd64(64'(s2_rz) * cfg.sc_z, 12);
      s3 <= s2;
    end
  end

  // Stage 4: offset, saturation and bypass when position mode is off.
  always_ff @(posedge clk) begin
    req_t r;
    if (en[3]) begin
      r = s3;
      if (cfg.pos_en) begin
        r.px = sat32(s3_sx + 64'(cfg.off_x));
        r.py = sat32(s3_sy + 64'(cfg.off_y));
        r.pz = sat32(s3_sz + 64'(cfg.off_z));
      end
      dout <= r;
    end
  end

endmodule

/* sv/pst_pipe_ctrl.sv */
// Valid and stall control for the four-stage pipeline.
// Depends on pst_pkg.
module pst_pipe_ctrl import pst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAGES-1:0] en
);

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   adv;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    adv[STAGES] = !out_stall;
    for (int i = STAGES - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign en        = adv[STAGES-1:0];
  assign in_stall  = !adv[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // A stalled result stays presented.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  // Input stall only when the pipeline is full up to the output.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld) && out_stall)
    else $error("spurious input stall");
  // An accepted request reaches stage one.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("request lost at entry");

endmodule

/* sv/pose_static_transform.sv */
// Top level of the pose static transform block: config registers, pipeline
// control and datapath. Depends on pst_pkg and the pst_* modules.
//
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//  input   | in        | in_valid/in_stall  | pos_*, ori_*, conf_in, buttons_in
//  output  | out       | out_valid/stall    | out_pos_*, out_ori_*, conf_out, ...
//
// One request enters every cycle while in_stall is low; the datapath has four
// register stages. Reset empties all stages. A stall at the output freezes
// the full stages from the output back to the first empty one, and backs up to
// in_stall only when every stage holds a request.
module pose_static_transform import pst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   pos_x, pos_y, pos_z,
  input  logic signed [15:0]   ori_x, ori_y, ori_z, ori_w,
  input  logic [15:0]          conf_in,
  input  logic [15:0]          buttons_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_pos_x, out_pos_y, out_pos_z,
  output logic signed [15:0]   out_ori_x, out_ori_y, out_ori_z, out_ori_w,
  output logic [15:0]          conf_out,
  output logic [15:0]          buttons_out
);

  cfg_t cfg;
  req_t din, dout;
  logic [STAGES-1:0] en;

  pst_cfg_regs u_cfg (.clk, .rst, .cfg_valid, .cfg_ready, .cfg_index,
                      .cfg_data, .cfg);

  pst_pipe_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .out_valid,
                        .out_stall, .en);

  assign din = '{px: pos_x, py: pos_y, pz: pos_z, ex: ori_x, ey: ori_y,
                 ez: ori_z, ew: ori_w, conf: conf_in, buttons: buttons_in};

  pst_datapath u_dp (.clk, .en, .cfg, .din, .dout);

  assign out_pos_x   = dout.px;
  assign out_pos_y   = dout.py;
  assign out_pos_z   = dout.pz;
  assign out_ori_x   = dout.ex;
  assign out_ori_y   = dout.ey;
  assign out_ori_z   = dout.ez;
  assign out_ori_w   = dout.ew;
  assign conf_out    = dout.conf;
  assign buttons_out = dout.buttons;

endmodule

/* sim/tb_pose_static_transform.sv */
// Self-checking testbench for pose_static_transform: it predicts the transform
// of each tracking event, or takes a given result for table rows, and compares the results in order.
// Depends on pst_pkg for the register indexes, the config index width and STAGES.
module tb_pose_static_transform import pst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [15:0] ex, ey, ez, ew;
    logic [15:0] conf;
    logic [15:0] buttons;
  } event_t;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [15:0] ox, oy, oz, ow;
    logic [15:0] conf;
    logic [15:0] buttons;
  } pose_t;

  typedef struct {
    event_t ev;
    bit     typed;
    pose_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] ori_x = '0, ori_y = '0, ori_z = '0, ori_w = '0;
  logic [15:0] conf_in = '0, buttons_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_ori_x, out_ori_y, out_ori_z, out_ori_w;
  logic [15:0] conf_out, buttons_out;

  // Shadow copy of the configuration registers.
  logic [63:0] rot_q;
  logic [31:0] offs [3];
  logic [47:0] scales;
  logic [15:0] gain;
  logic [1:0]  mode;

  pose_t pose_pending [$];
  int    errors = 0;
  bit    hold_req = 0;
  bit    quiet = 0;

  pose_static_transform dut (.*);

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("** pose_static_transform: FAILED **");
    $finish;
  end

  function automatic longint rnd(longint a, int n);
    return (a + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat(longint a, longint lo, longint hi);
    return a < lo ? lo : (a > hi ? hi : a);
  endfunction

  function automatic longint s16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint s32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic pose_t predict_pose(event_t e);
    pose_t  r;
    longint qx, qy, qz, qw, vx, vy, vz, ex, ey, ez, ew;
    longint tw, tx, ty, tz, rx, ry, rz;
    logic [32:0] c;
    qx = s16(rot_q[15:0]);  qy = s16(rot_q[31:16]);
    qz = s16(rot_q[47:32]); qw = s16(rot_q[63:48]);
    vx = s32(e.px); vy = s32(e.py); vz = s32(e.pz);
    ex = s16(e.ex); ey = s16(e.ey); ez = s16(e.ez); ew = s16(e.ew);
    r.px = e.px; r.py = e.py; r.pz = e.pz;
    r.ox = e.ex; r.oy = e.ey; r.oz = e.ez; r.ow = e.ew;
    if (mode[0]) begin
      // Rotate as q v q*, keeping only the vector part of the second product.
      tw = rnd(-(qx * vx + qy * vy + qz * vz), 14);
      tx = rnd(qw * vx + qy * vz - qz * vy, 14);
      ty = rnd(qw * vy + qz * vx - qx * vz, 14);
      tz = rnd(qw * vz + qx * vy - qy * vx, 14);
      rx = rnd(-tw * qx + tx * qw - ty * qz + tz * qy, 14);
      ry = rnd(-tw * qy + tx * qz + ty * qw - tz * qx, 14);
      rz = rnd(-tw * qz - tx * qy + ty * qx + tz * qw, 14);
      r.px = 32'(sat(rnd(rx * s16(scales[15:0]), 12) + s32(offs[0]),
                     -64'sd2147483648, 64'sd2147483647));
      r.py = 32'(sat(rnd(ry * s16(scales[31:16]), 12) + s32(offs[1]),
                     -64'sd2147483648, 64'sd2147483647));
      r.pz = 32'(sat(rnd(rz * s16(scales[47:32]), 12) + s32(offs[2]),
                     -64'sd2147483648, 64'sd2147483647));
    end
    if (mode[1]) begin
      r.ow = 16'(sat(rnd(qw * ew - qx * ex - qy * ey - qz * ez, 14), -32768, 32767));
      r.ox = 16'(sat(rnd(qw * ex + qx * ew + qy * ez - qz * ey, 14), -32768, 32767));
      r.oy = 16'(sat(rnd(qw * ey - qx * ez + qy * ew + qz * ex, 14), -32768, 32767));
      r.oz = 16'(sat(rnd(qw * ez + qx * ey - qy * ex + qz * ew, 14), -32768, 32767));
    end
    c = (({17'd0, e.conf} * {17'd0, gain}) + 33'd16384) >> 15;
    r.conf = (c > 33'd32768) ? 16'd32768 : c[15:0];
    r.buttons = e.buttons;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROT:   rot_q = val;
      REG_OFF_X: offs[0] = val[31:0];
      REG_OFF_Y: offs[1] = val[31:0];
      REG_OFF_Z: offs[2] = val[31:0];
      REG_SCALE: scales = val[47:0];
      REG_GAIN:  gain = val[15:0];
      REG_MODE:  mode = val[1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [63:0] q, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [47:0] s, logic [15:0] g,
                           logic [1:0] m);
    write_reg(REG_ROT, q);
    write_reg(REG_OFF_X, {$urandom, x});
    write_reg(REG_OFF_Y, {32'd0, y});
    write_reg(REG_OFF_Z, {32'd0, z});
    write_reg(REG_SCALE, {16'hffff, s});
    write_reg(REG_GAIN, {48'd0, g});
    write_reg(REG_MODE, {62'd0, m});
  endtask

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_event(event_t e, bit typed, pose_t res);
    int gap;
    pos_x <= e.px; pos_y <= e.py; pos_z <= e.pz;
    ori_x <= e.ex; ori_y <= e.ey; ori_z <= e.ez; ori_w <= e.ew;
    conf_in <= e.conf; buttons_in <= e.buttons;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pose_pending.push_back(typed ? res : predict_pose(e));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic event_t rand_event();
    event_t e;
    int p;
    p = $urandom_range(0, 9);
    e.px = $urandom; e.py = $urandom; e.pz = $urandom;
    if (p < 4) begin
      // Moderate positions keep most results away from saturation.
      e.px = $signed(e.px) >>> $urandom_range(0, 12);
      e.py = $signed(e.py) >>> $urandom_range(0, 12);
      e.pz = $signed(e.pz) >>> $urandom_range(0, 12);
    end
    e.ex = 16'($urandom); e.ey = 16'($urandom);
    e.ez = 16'($urandom); e.ew = 16'($urandom);
    e.conf = (p == 9) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    e.buttons = 16'($urandom);
    return e;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    wait (pose_pending.size() == 0);
    repeat (2 * STAGES + 4) @(posedge clk);
  endtask

  task automatic random_events(int n);
    pose_t dummy;
    dummy = '0;
    repeat (n) send_event(rand_event(), 1'b0, dummy);
  endtask

  // Output side: checks each accepted result and drives a random stall.
  initial begin
    pose_t exp_r, got;
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = {out_pos_x, out_pos_y, out_pos_z, out_ori_x, out_ori_y, out_ori_z,
               out_ori_w, conf_out, buttons_out};
        if (pose_pending.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = pose_pending.pop_front();
          if (got.px !== exp_r.px || got.py !== exp_r.py || got.pz !== exp_r.pz) begin
            $display("%0t: position expected %h %h %h actual %h %h %h", $time,
                     exp_r.px, exp_r.py, exp_r.pz, got.px, got.py, got.pz);
            errors++;
          end
          if (got.ox !== exp_r.ox || got.oy !== exp_r.oy || got.oz !== exp_r.oz ||
              got.ow !== exp_r.ow) begin
            $display("%0t: orientation expected %h %h %h %h actual %h %h %h %h",
                     $time, exp_r.ox, exp_r.oy, exp_r.oz, exp_r.ow,
                     got.ox, got.oy, got.oz, got.ow);
            errors++;
          end
          if (got.conf !== exp_r.conf || got.buttons !== exp_r.buttons) begin
            $display("%0t: conf/buttons expected %h %h actual %h %h", $time,
                     exp_r.conf, exp_r.buttons, got.conf, got.buttons);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    row_t table_rows [$];
    row_t row;
    event_t e;
    rot_q = 64'h4000_0000_0000_0000;
    offs[0] = '0; offs[1] = '0; offs[2] = '0;
    scales = 48'h1000_1000_1000;
    gain = 16'd32768;
    mode = 2'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of every field; after reset the block passes them through.
    e = {32'h7fffffff, 32'h80000000, 32'h0, 16'h7fff, 16'h8000, 16'h0,
         16'h4000, 16'd32768, 16'hffff};
    table_rows.push_back('{e, 1, {e.px, e.py, e.pz, e.ex, e.ey, e.ez, e.ew,
                                  16'd32768, e.buttons}});
    e = {32'h80000000, 32'h7fffffff, 32'hffffffff, 16'h8000, 16'h7fff,
         16'hffff, 16'h8000, 16'd0, 16'h0};
    table_rows.push_back('{e, 1, {e.px, e.py, e.pz, e.ex, e.ey, e.ez, e.ew,
                                  16'd0, e.buttons}});
    // Confidence overflow saturates to one.
    e = {32'h00010000, 32'h00020000, 32'h00030000, 16'h0, 16'h0, 16'h0,
         16'h4000, 16'hffff, 16'h5a5a};
    table_rows.push_back('{e, 1, {e.px, e.py, e.pz, e.ex, e.ey, e.ez, e.ew,
                                  16'd32768, e.buttons}});
    e = {32'h00000001, 32'hfffffffe, 32'h12345678, 16'h2d41, 16'h0, 16'h0,
         16'h2d41, 16'd16384, 16'ha5a5};
    table_rows.push_back('{e, 1, {e.px, e.py, e.pz, e.ex, e.ey, e.ez, e.ew,
                                  16'd16384, e.buttons}});
    for (int i = 0; i < 6; i++) begin
      row.ev = rand_event();
      row.typed = 0;
      row.res = '0;
      table_rows.push_back(row);
    end
    foreach (table_rows[i]) send_event(table_rows[i].ev, table_rows[i].typed,
                                       table_rows[i].res);
    drain();

    // Same rows through a quarter turn about z, both modes, unit scale.
    write_all(64'h2d41_2d41_0000_0000, 32'h0001_0000, 32'hffff_0000, 32'h0,
              48'h1000_1000_1000, 16'd32768, 2'd3);
    foreach (table_rows[i]) send_event(table_rows[i].ev, 1'b0, '0);
    drain();
    // An unknown register index must leave everything unchanged.
    write_reg(3'd7, 64'hffff_ffff_ffff_ffff);
    // Extreme registers: most negative quaternion, full offsets and scales.
    write_all(64'h8000_8000_8000_8000, 32'h7fff_ffff, 32'h8000_0000,
              32'hffff_ffff, 48'h7fff_8000_ffff, 16'hffff, 2'd1);
    for (int i = 0; i < 4; i++) send_event(table_rows[i].ev, 1'b0, '0);
    drain();

    // Back-pressure: a long receiver hold while the sender keeps offering.
    write_all(64'h7fff_7fff_7fff_7fff, 32'h0, 32'h0, 32'h0, 48'h0, 16'd0, 2'd2);
    quiet = 1;
    hold_req = 1;
    random_events(40);
    quiet = 0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0)
        write_all({$urandom, $urandom}, $urandom, $urandom, $urandom,
                  {16'($urandom), $urandom}, 16'($urandom), 2'($urandom));
      else
        // Small quaternion components and modest scales keep results in range.
        write_all({16'($urandom_range(0, 16383)), 16'($urandom_range(0, 8191)),
                   16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191))},
                  $urandom >> 8, $urandom >> 8, $urandom >> 8,
                  {16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                   16'($urandom_range(0, 8191))},
                  16'($urandom_range(0, 32768)), 2'($urandom));
      random_events(70);
      drain();
    end

    if (errors == 0)
      $display("** pose_static_transform: PASSED **");
    else
      $display("** pose_static_transform: FAILED **");
    $finish;
  end

endmodule
